@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted (active low)
`define CHK_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is asserted (active low)
`define CHK_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/tcce_pkg.sv @@
// Shared types and constants of the text console cursor engine.
// No dependencies; used by tcce_update, the top level, the checker and the bench.
`default_nettype none

package tcce_pkg;

    localparam int unsigned ADDR_W      = 14;
    localparam int unsigned SIZE_W      = 15;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned REQ_W       = 2;
    localparam int unsigned EXT_W       = 17;  // room for base + size and view + cells
    localparam int unsigned WIDTH_LOG2_MAX = 8; // screen width is at most 256

    localparam int unsigned SCREEN_WIDTH_DEF = 80;
    localparam int unsigned SCREEN_CELLS_DEF = 2000;
    localparam int unsigned BLANK_ATTR_DEF   = 7;

    localparam int unsigned S_TDATA_W  = 16;
    localparam int unsigned M_TDATA_W  = 64;
    localparam int unsigned M_PAD_W    = M_TDATA_W - (3 * ADDR_W + 2 * BYTE_W);
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = SIZE_W;

    localparam logic [SIZE_W-1:0] REGION_SIZE_RESET = 15'd16384;

    localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [BYTE_W-1:0] CH_SPACE     = 8'd32;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE = 8'd1;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUT         = 2'd0,
        REQ_SCROLL_UP   = 2'd1,
        REQ_SCROLL_DOWN = 2'd2
    } req_t;

    typedef struct packed {
        logic              cell_write;
        logic [ADDR_W-1:0] cell_addr;
        logic [BYTE_W-1:0] cell_char;
        logic [BYTE_W-1:0] cell_attr;
        logic [ADDR_W-1:0] cursor_pos;
        logic [ADDR_W-1:0] view_start;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/tcce_update.sv @@
// Next-state and result logic for one console request.
// Depends on tcce_pkg; instantiated by text_console_cursor_engine_core.
`default_nettype none

module tcce_update #(
    parameter int unsigned SCREEN_WIDTH = tcce_pkg::SCREEN_WIDTH_DEF,
    parameter int unsigned SCREEN_CELLS = tcce_pkg::SCREEN_CELLS_DEF,
    parameter int unsigned BLANK_ATTR   = tcce_pkg::BLANK_ATTR_DEF
) (
    input  logic [tcce_pkg::ADDR_W-1:0] region_base,
    input  logic [tcce_pkg::SIZE_W-1:0] region_size,
    input  logic [tcce_pkg::ADDR_W-1:0] cursor,
    input  logic [tcce_pkg::ADDR_W-1:0] view,
    input  logic [tcce_pkg::REQ_W-1:0]  req_type,
    input  logic [tcce_pkg::BYTE_W-1:0] char_code,
    input  logic [tcce_pkg::BYTE_W-1:0] color_attr,
    output tcce_pkg::result_t           res
);

    localparam int unsigned AW = tcce_pkg::ADDR_W;
    localparam int unsigned XW = tcce_pkg::EXT_W;
    // round-up reciprocal; exact for every 14-bit dividend since the
    // rounding error times the dividend stays below 2^RECIP_SHIFT
    localparam int unsigned RECIP_SHIFT = AW + tcce_pkg::WIDTH_LOG2_MAX;
    localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
    localparam int unsigned RECIP       = ((1 << RECIP_SHIFT) + SCREEN_WIDTH - 1) / SCREEN_WIDTH;
    localparam int unsigned SPAN_W      = AW + tcce_pkg::WIDTH_LOG2_MAX + 1;

    localparam logic [RECIP_W-1:0] RECIP_C  = RECIP_W'(RECIP);
    localparam logic [AW-1:0]      WIDTH_A  = AW'(SCREEN_WIDTH);
    localparam logic [XW-1:0]      WIDTH_X  = XW'(SCREEN_WIDTH);
    localparam logic [XW-1:0]      CELLS_X  = XW'(SCREEN_CELLS);
    localparam logic [tcce_pkg::BYTE_W-1:0] BLANK_C = tcce_pkg::BYTE_W'(BLANK_ATTR);

    logic [XW-1:0]          region_end;
    logic [XW-1:0]          cursor_x;
    logic [XW-1:0]          view_x;
    logic [AW-1:0]          offset;
    logic [AW+RECIP_W-1:0]  recip_prod;
    logic [AW-1:0]          row_inc;
    logic [SPAN_W-1:0]      span;
    logic [AW-1:0]          nl_cursor;
    logic [AW-1:0]          cursor_n;
    logic [AW-1:0]          view_n;

    assign region_end = XW'(region_base) + XW'(region_size);
    assign cursor_x   = XW'(cursor);
    assign view_x     = XW'(view);

    // row of the cursor within the region, then start of the following row
    assign offset     = cursor - region_base;
    assign recip_prod = (AW + RECIP_W)'(offset) * (AW + RECIP_W)'(RECIP_C);
    assign row_inc    = recip_prod[RECIP_SHIFT +: AW] + AW'(1);
    assign span       = SPAN_W'(row_inc) * SPAN_W'(WIDTH_A);
    assign nl_cursor  = (cursor < region_base) ? region_base
                                               : region_base + span[AW-1:0];

    always_comb begin
        res      = '0;
        cursor_n = cursor;
        view_n   = view;
        unique case (req_type)
            tcce_pkg::REQ_PUT: begin
                case (char_code)
                    tcce_pkg::CH_NEWLINE: begin
                        if (cursor_x + WIDTH_X < region_end) begin
                            cursor_n = nl_cursor;
                        end
                    end
                    tcce_pkg::CH_BACKSPACE: begin
                        if (cursor > region_base) begin
                            cursor_n       = cursor - AW'(1);
                            res.cell_write = 1'b1;
                            res.cell_addr  = cursor - AW'(1);
                            res.cell_char  = tcce_pkg::CH_SPACE;
                            res.cell_attr  = BLANK_C;
                        end
                    end
                    default: begin
                        // last cell of the region is never written
                        if (cursor_x + XW'(1) < region_end) begin
                            cursor_n       = cursor + AW'(1);
                            res.cell_write = 1'b1;
                            res.cell_addr  = cursor;
                            res.cell_char  = char_code;
                            res.cell_attr  = color_attr;
                        end
                    end
                endcase
            end
            tcce_pkg::REQ_SCROLL_UP: begin
                if (view > region_base) begin
                    view_n = view - WIDTH_A;
                end
            end
            tcce_pkg::REQ_SCROLL_DOWN: begin
                if (view_x + CELLS_X < region_end) begin
                    view_n = view + WIDTH_A;
                end
            end
            default: begin
                // unused request code: state unchanged
            end
        endcase
        res.cursor_pos = cursor_n;
        res.view_start = view_n;
    end

endmodule

`default_nettype wire

@@ rtl/text_console_cursor_engine_core.sv @@
// Top level of the text console cursor engine: state, config and output register.
// Depends on tcce_pkg and tcce_update.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-----------------------------------------
//  s_      | in  | s_tvalid / s_tready   | tuser req_type; tdata char, attr
//  m_      | out | m_tvalid / m_tready   | tuser cell_write; tdata cell, cursor, view
//  cfg_    | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request per cycle unless the output stalls; each result is registered.
// The cursor and view registers are updated in the accepting cycle, so a
// request sees the state left by the one before it with no bubble.
// s_tready drops only while a result waits in the output register and m_tready
// is low. cfg_ready is always high. Reset is synchronous, active low, and
// leaves cursor and view at zero, region base zero, region size 16384.
`default_nettype none

module text_console_cursor_engine_core #(
    parameter int unsigned SCREEN_WIDTH = tcce_pkg::SCREEN_WIDTH_DEF,
    parameter int unsigned SCREEN_CELLS = tcce_pkg::SCREEN_CELLS_DEF,
    parameter int unsigned BLANK_ATTR   = tcce_pkg::BLANK_ATTR_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tcce_pkg::S_TDATA_W-1:0]      s_tdata,  // char_code, color_attr
    input  logic [tcce_pkg::REQ_W-1:0]          s_tuser,  // req_type
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // cell_addr, cell_char, cell_attr, cursor_pos, view_start, zero pad
    output logic [tcce_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tuser,  // cell_write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tcce_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tcce_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int unsigned AW = tcce_pkg::ADDR_W;
    localparam int unsigned BW = tcce_pkg::BYTE_W;

    logic [AW-1:0]              cursor_reg;
    logic [AW-1:0]              view_reg;
    logic [AW-1:0]              base_reg;
    logic [tcce_pkg::SIZE_W-1:0] size_reg;
    logic                       m_valid_reg;
    tcce_pkg::result_t          out_reg;
    tcce_pkg::result_t          out_next;
    logic                       accept;

    tcce_update #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_CELLS (SCREEN_CELLS),
        .BLANK_ATTR   (BLANK_ATTR)
    ) u_update (
        .region_base (base_reg),
        .region_size (size_reg),
        .cursor      (cursor_reg),
        .view        (view_reg),
        .req_type    (s_tuser),
        .char_code   (s_tdata[BW-1:0]),
        .color_attr  (s_tdata[2*BW-1:BW]),
        .res         (out_next)
    );

    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_reg.cell_write;
    assign m_tdata  = {{tcce_pkg::M_PAD_W{1'b0}}, out_reg.view_start, out_reg.cursor_pos,
                       out_reg.cell_attr, out_reg.cell_char, out_reg.cell_addr};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg  <= '0;
            view_reg    <= '0;
            base_reg    <= '0;
            size_reg    <= tcce_pkg::REGION_SIZE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                cursor_reg  <= out_next.cursor_pos;
                view_reg    <= out_next.view_start;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    tcce_pkg::CFG_REGION_BASE: base_reg <= cfg_data[AW-1:0];
                    tcce_pkg::CFG_REGION_SIZE: size_reg <= cfg_data;
                    default: begin
                        // no register at this index
                    end
                endcase
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tcce_checker.sv @@
// Port-level checks for text_console_cursor_engine_core, bound to the top level.
// Depends on tcce_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tcce_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [tcce_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                           m_tuser
);

    localparam int unsigned AW = tcce_pkg::ADDR_W;

    logic [AW-1:0] chk_addr;
    logic [AW-1:0] chk_addr_inc;
    logic [AW-1:0] chk_cursor;

    assign chk_addr     = m_tdata[AW-1:0];
    assign chk_addr_inc = chk_addr + AW'(1);
    assign chk_cursor   = m_tdata[3*AW+1:2*AW+2];

    `CHK_NEXT(a_valid_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `CHK_NEXT(a_data_hold, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `CHK_NEXT(a_one_cycle, aclk, aresetn, s_tvalid && s_tready, m_tvalid, "accepted word gave no result next cycle")
    `CHK_IMPL(a_no_write_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata[AW+15:0] == '0, "cell fields set without a write")
    `CHK_IMPL(a_write_cursor, aclk, aresetn, m_tvalid && m_tuser, (chk_cursor == chk_addr) || (chk_cursor == chk_addr_inc), "cursor not next to written cell")

endmodule

bind text_console_cursor_engine_core tcce_checker u_tcce_checker (.*);

`default_nettype wire

@@ test/text_console_cursor_engine_core_tb.sv @@
// Self-checking bench for text_console_cursor_engine_core: directed table, then random
// request traffic checked against a cursor predictor. Needs tcce_pkg and the core.
`timescale 1ns / 1ps

module text_console_cursor_engine_core_tb;

    localparam int unsigned ADDR_W     = tcce_pkg::ADDR_W;
    localparam int unsigned SIZE_W     = tcce_pkg::SIZE_W;
    localparam int unsigned BYTE_W     = tcce_pkg::BYTE_W;
    localparam int unsigned REQ_W      = tcce_pkg::REQ_W;
    localparam int unsigned CFG_IDX_W  = tcce_pkg::CFG_IDX_W;
    localparam int unsigned CFG_DATA_W = tcce_pkg::CFG_DATA_W;
    localparam int unsigned S_TDATA_W  = tcce_pkg::S_TDATA_W;
    localparam int unsigned M_TDATA_W  = tcce_pkg::M_TDATA_W;
    localparam int unsigned M_PAD_W    = tcce_pkg::M_PAD_W;

    localparam int unsigned LINE_CELLS  = tcce_pkg::SCREEN_WIDTH_DEF;
    localparam int unsigned STALL_LIMIT = 5000;
    localparam logic [BYTE_W-1:0] BLANK = BYTE_W'(tcce_pkg::BLANK_ATTR_DEF);
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'hFF;

    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [REQ_W-1:0]      req;
        logic [BYTE_W-1:0]     ch;
        logic [BYTE_W-1:0]     attr;
        logic                  typed;
        tcce_pkg::result_t     want;
    } script_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [REQ_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor state
    logic [ADDR_W-1:0] cursor_q = '0;
    logic [ADDR_W-1:0] view_q = '0;
    logic [ADDR_W-1:0] base_q = '0;
    logic [SIZE_W-1:0] size_q = tcce_pkg::REGION_SIZE_RESET;

    tcce_pkg::result_t result_q[$];
    script_row_t script[$];
    int unsigned send_idle_pct = 12;
    int unsigned recv_idle_pct = 79;
    int unsigned mismatches = 0;
    int unsigned words_sent = 0;
    int unsigned results_seen = 0;
    int unsigned cfg_writes = 0;
    int unsigned quiet_cycles = 0;

    text_console_cursor_engine_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Advance the console state by one request and return the word it should produce.
    function automatic tcce_pkg::result_t console_step(input logic [REQ_W-1:0] req,
                                                       input logic [BYTE_W-1:0] ch,
                                                       input logic [BYTE_W-1:0] attr);
        tcce_pkg::result_t r;
        int unsigned cur;
        int unsigned view;
        int unsigned top;
        r = '0;
        cur = cursor_q;
        view = view_q;
        top = base_q + size_q;  // region end, no wrap
        if (req == tcce_pkg::REQ_PUT) begin
            if (ch == tcce_pkg::CH_NEWLINE) begin
                if (cur + LINE_CELLS < top) begin
                    if (cur < base_q)
                        cur = base_q;
                    else
                        cur = base_q + LINE_CELLS * ((cur - base_q) / LINE_CELLS + 1);
                end
            end else if (ch == tcce_pkg::CH_BACKSPACE) begin
                if (cur > base_q) begin
                    cur = cur - 1;
                    r.cell_write = 1'b1;
                    r.cell_addr = ADDR_W'(cur);
                    r.cell_char = tcce_pkg::CH_SPACE;
                    r.cell_attr = BLANK;
                end
            end else if (cur + 1 < top) begin
                r.cell_write = 1'b1;
                r.cell_addr = ADDR_W'(cur);
                r.cell_char = ch;
                r.cell_attr = attr;
                cur = cur + 1;
            end
        end else if (req == tcce_pkg::REQ_SCROLL_UP) begin
            if (view > base_q)
                view = view - LINE_CELLS;
        end else if (req == tcce_pkg::REQ_SCROLL_DOWN) begin
            if (view + tcce_pkg::SCREEN_CELLS_DEF < top)
                view = view + LINE_CELLS;
        end
        cursor_q = ADDR_W'(cur);
        view_q = ADDR_W'(view);
        r.cursor_pos = cursor_q;
        r.view_start = view_q;
        return r;
    endfunction

    function automatic script_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] val);
        script_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic script_row_t word_row(input logic [REQ_W-1:0] req,
                                             input logic [BYTE_W-1:0] ch,
                                             input logic [BYTE_W-1:0] attr);
        script_row_t r;
        r = '0;
        r.req = req;
        r.ch = ch;
        r.attr = attr;
        return r;
    endfunction

    function automatic script_row_t typed_row(input logic [REQ_W-1:0] req,
                                              input logic [BYTE_W-1:0] ch,
                                              input logic [BYTE_W-1:0] attr,
                                              input logic wr,
                                              input logic [ADDR_W-1:0] addr,
                                              input logic [BYTE_W-1:0] c,
                                              input logic [BYTE_W-1:0] a,
                                              input logic [ADDR_W-1:0] cur,
                                              input logic [ADDR_W-1:0] view);
        script_row_t r;
        r = word_row(req, ch, attr);
        r.typed = 1'b1;
        r.want = '{wr, addr, c, a, cur, view};
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("%0t: %s mismatch on result %0d: got 0x%0h, want 0x%0h",
                 $time, what, results_seen, got, want);
    endtask

    task automatic compare_result(input tcce_pkg::result_t want);
        if (m_tuser !== want.cell_write)
            report_mismatch("cell_write", m_tuser, want.cell_write);
        if (m_tdata[0 +: ADDR_W] !== want.cell_addr)
            report_mismatch("cell_addr", m_tdata[0 +: ADDR_W], want.cell_addr);
        if (m_tdata[ADDR_W +: BYTE_W] !== want.cell_char)
            report_mismatch("cell_char", m_tdata[ADDR_W +: BYTE_W], want.cell_char);
        if (m_tdata[ADDR_W+BYTE_W +: BYTE_W] !== want.cell_attr)
            report_mismatch("cell_attr", m_tdata[ADDR_W+BYTE_W +: BYTE_W], want.cell_attr);
        if (m_tdata[ADDR_W+2*BYTE_W +: ADDR_W] !== want.cursor_pos)
            report_mismatch("cursor_pos", m_tdata[ADDR_W+2*BYTE_W +: ADDR_W], want.cursor_pos);
        if (m_tdata[2*ADDR_W+2*BYTE_W +: ADDR_W] !== want.view_start)
            report_mismatch("view_start", m_tdata[2*ADDR_W+2*BYTE_W +: ADDR_W],
                            want.view_start);
        if (m_tdata[M_TDATA_W-1 -: M_PAD_W] !== '0)
            report_mismatch("tdata pad", m_tdata[M_TDATA_W-1 -: M_PAD_W], 0);
    endtask

    // Hands one word to the block; returns at the edge that took it, tvalid still high.
    task automatic send_word(input logic [REQ_W-1:0] req, input logic [BYTE_W-1:0] ch,
                             input logic [BYTE_W-1:0] attr, input logic typed,
                             input tcce_pkg::result_t want);
        tcce_pkg::result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {attr, ch};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = console_step(req, ch, attr);
        result_q.push_back(typed ? want : predicted);
        words_sent++;
    endtask

    task automatic send_request(input logic [REQ_W-1:0] req, input logic [BYTE_W-1:0] ch,
                                input logic [BYTE_W-1:0] attr);
        send_word(req, ch, attr, 1'b0, '0);
    endtask

    // Stop sending and wait for every pending result; ends on a rising edge.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (result_q.size() != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == tcce_pkg::CFG_REGION_BASE)
            base_q = val[ADDR_W-1:0];
        else if (idx == tcce_pkg::CFG_REGION_SIZE)
            size_q = val;
        cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_idle(input int unsigned mode);
        case (mode)
            0: begin send_idle_pct = 12; recv_idle_pct = 79; end
            1: begin send_idle_pct = 79; recv_idle_pct = 12; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
        endcase
    endtask

    // Mostly text lines ended by newline, plus backspace runs, scroll bursts, newline bursts and noise.
    task automatic random_traffic(input int unsigned count);
        int unsigned sent;
        int unsigned kind;
        int unsigned len;
        int unsigned k;
        logic [REQ_W-1:0] dir;
        logic [BYTE_W-1:0] ch;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                len = $urandom_range(0, 90);
                for (k = 0; k < len; k++) begin
                    ch = ($urandom_range(0, 7) == 0) ? BYTE_W'($urandom)
                                                      : BYTE_W'($urandom_range(32, 126));
                    send_request(tcce_pkg::REQ_PUT, ch, BYTE_W'($urandom));
                end
                send_request(tcce_pkg::REQ_PUT, tcce_pkg::CH_NEWLINE, BYTE_W'($urandom));
                sent += len + 1;
            end else if (kind < 60) begin
                len = $urandom_range(1, 12);
                repeat (len)
                    send_request(tcce_pkg::REQ_PUT, tcce_pkg::CH_BACKSPACE, BYTE_W'($urandom));
                sent += len;
            end else if (kind < 75) begin
                len = $urandom_range(1, 40);
                dir = ($urandom_range(0, 1) == 0) ? tcce_pkg::REQ_SCROLL_UP
                                                   : tcce_pkg::REQ_SCROLL_DOWN;
                repeat (len) send_request(dir, BYTE_W'($urandom), BYTE_W'($urandom));
                sent += len;
            end else if (kind < 85) begin
                len = $urandom_range(1, 5);
                repeat (len)
                    send_request(tcce_pkg::REQ_PUT, tcce_pkg::CH_NEWLINE, BYTE_W'($urandom));
                sent += len;
            end else begin
                len = $urandom_range(1, 8);
                for (k = 0; k < len; k++) begin
                    if ($urandom_range(0, 3) == 0)
                        ch = ($urandom_range(0, 1) == 0) ? tcce_pkg::CH_NEWLINE
                                                          : tcce_pkg::CH_BACKSPACE;
                    else
                        ch = BYTE_W'($urandom);
                    send_request(REQ_W'($urandom_range(0, 3)), ch, BYTE_W'($urandom));
                end
                sent += len;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (result_q.size() == 0)
                report_mismatch("unexpected word", m_tdata, 0);
            else
                compare_result(result_q.pop_front());
            results_seen++;
        end
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        script_row_t row;
        int unsigned i;
        int unsigned phase;

        // after reset: base 0, size 16384, cursor 0, view 0
        script.push_back(typed_row(tcce_pkg::REQ_PUT, 8'h41, 8'hFF, 1, 0, 8'h41, 8'hFF,
                                   1, 0));
        script.push_back(typed_row(tcce_pkg::REQ_PUT, tcce_pkg::CH_BACKSPACE, 8'h12,
                                   1, 0, tcce_pkg::CH_SPACE, BLANK, 0, 0));
        script.push_back(typed_row(tcce_pkg::REQ_PUT, tcce_pkg::CH_BACKSPACE, 8'h12,
                                   0, 0, 0, 0, 0, 0));
        script.push_back(typed_row(tcce_pkg::REQ_PUT, tcce_pkg::CH_NEWLINE, 8'h00,
                                   0, 0, 0, 0, 80, 0));
        script.push_back(typed_row(tcce_pkg::REQ_SCROLL_UP, 8'h00, 8'h00, 0, 0, 0, 0, 80, 0));
        script.push_back(typed_row(tcce_pkg::REQ_SCROLL_DOWN, 8'h00, 8'h00,
                                   0, 0, 0, 0, 80, 80));
        script.push_back(typed_row(REQ_UNUSED, 8'hFF, 8'hFF, 0, 0, 0, 0, 80, 80));
        script.push_back(typed_row(tcce_pkg::REQ_PUT, 8'h00, 8'h00, 1, 80, 8'h00, 8'h00,
                                   81, 80));
        script.push_back(typed_row(tcce_pkg::REQ_PUT, 8'hFF, 8'hFF, 1, 81, 8'hFF, 8'hFF,
                                   82, 80));
        script.push_back(typed_row(tcce_pkg::REQ_SCROLL_UP, 8'h00, 8'h00, 0, 0, 0, 0, 82, 0));
        // empty region: nothing moves forward
        script.push_back(cfg_row(tcce_pkg::CFG_REGION_SIZE, 0));
        script.push_back(typed_row(tcce_pkg::REQ_PUT, 8'h78, 8'h1E, 0, 0, 0, 0, 82, 0));
        script.push_back(typed_row(tcce_pkg::REQ_PUT, tcce_pkg::CH_NEWLINE, 8'h1E,
                                   0, 0, 0, 0, 82, 0));
        script.push_back(typed_row(tcce_pkg::REQ_SCROLL_DOWN, 8'h00, 8'h00,
                                   0, 0, 0, 0, 82, 0));
        script.push_back(cfg_row(CFG_IDX_SPARE, 15'h7FFF));
        // top base, oversized region: newline from below base, write wraps cursor
        script.push_back(cfg_row(tcce_pkg::CFG_REGION_BASE, 15'h3FFF));
        script.push_back(cfg_row(tcce_pkg::CFG_REGION_SIZE, 15'h7FFF));
        script.push_back(typed_row(tcce_pkg::REQ_PUT, tcce_pkg::CH_NEWLINE, 8'h00,
                                   0, 0, 0, 0, 16383, 0));
        script.push_back(typed_row(tcce_pkg::REQ_PUT, 8'h5A, 8'hA5, 1, 16383, 8'h5A, 8'hA5,
                                   0, 0));
        script.push_back(typed_row(tcce_pkg::REQ_SCROLL_DOWN, 8'h00, 8'h00,
                                   0, 0, 0, 0, 0, 80));
        script.push_back(typed_row(tcce_pkg::REQ_SCROLL_UP, 8'h00, 8'h00, 0, 0, 0, 0, 0, 80));
        script.push_back(typed_row(tcce_pkg::REQ_PUT, tcce_pkg::CH_NEWLINE, 8'h00,
                                   0, 0, 0, 0, 16383, 80));
        // three-cell region: a put never writes the last cell, but backspace blanks it
        script.push_back(cfg_row(tcce_pkg::CFG_REGION_BASE, 15'd16380));
        script.push_back(cfg_row(tcce_pkg::CFG_REGION_SIZE, 15'd3));
        script.push_back(typed_row(tcce_pkg::REQ_PUT, 8'h61, 8'h0F, 0, 0, 0, 0, 16383, 80));
        script.push_back(typed_row(tcce_pkg::REQ_PUT, tcce_pkg::CH_BACKSPACE, 8'h0F,
                                   1, 16382, tcce_pkg::CH_SPACE, BLANK, 16382, 80));
        script.push_back(typed_row(tcce_pkg::REQ_PUT, 8'h61, 8'h0F, 0, 0, 0, 0, 16382, 80));
        script.push_back(typed_row(tcce_pkg::REQ_PUT, tcce_pkg::CH_BACKSPACE, 8'h0F,
                                   1, 16381, tcce_pkg::CH_SPACE, BLANK, 16381, 80));
        script.push_back(typed_row(tcce_pkg::REQ_PUT, 8'h62, 8'hF0, 1, 16381, 8'h62, 8'hF0,
                                   16382, 80));
        script.push_back(typed_row(tcce_pkg::REQ_SCROLL_DOWN, 8'h00, 8'h00,
                                   0, 0, 0, 0, 16382, 160));
        // newline past the top of the address space, then from below the base
        script.push_back(cfg_row(tcce_pkg::CFG_REGION_BASE, 15'd100));
        script.push_back(cfg_row(tcce_pkg::CFG_REGION_SIZE, tcce_pkg::REGION_SIZE_RESET));
        script.push_back(word_row(tcce_pkg::REQ_PUT, tcce_pkg::CH_NEWLINE, 8'h00));
        script.push_back(word_row(tcce_pkg::REQ_SCROLL_UP, 8'h00, 8'h00));
        script.push_back(word_row(tcce_pkg::REQ_PUT, tcce_pkg::CH_NEWLINE, 8'h00));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_idle(0);
        for (i = 0; i < script.size(); i++) begin
            row = script[i];
            if (row.is_cfg) begin
                settle();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                send_word(row.req, row.ch, row.attr, row.typed, row.want);
            end
        end

        for (phase = 0; phase < 6; phase++) begin
            set_idle(phase / 2);
            settle();
            case (phase)
                0: begin
                    write_reg(tcce_pkg::CFG_REGION_BASE, CFG_DATA_W'($urandom_range(0, 200)));
                    write_reg(tcce_pkg::CFG_REGION_SIZE, tcce_pkg::REGION_SIZE_RESET);
                end
                1: begin
                    write_reg(tcce_pkg::CFG_REGION_BASE, 15'd4000);
                    write_reg(tcce_pkg::CFG_REGION_SIZE,
                              CFG_DATA_W'(tcce_pkg::SCREEN_CELLS_DEF));
                end
                2: begin
                    write_reg(tcce_pkg::CFG_REGION_BASE, 15'd0);
                    write_reg(tcce_pkg::CFG_REGION_SIZE, 15'h7FFF);
                end
                3: begin
                    write_reg(tcce_pkg::CFG_REGION_BASE,
                              CFG_DATA_W'($urandom_range(0, 16383)));
                    write_reg(tcce_pkg::CFG_REGION_SIZE, CFG_DATA_W'($urandom_range(1, 300)));
                end
                4: begin
                    write_reg(tcce_pkg::CFG_REGION_BASE, 15'h3FFF);
                    write_reg(tcce_pkg::CFG_REGION_SIZE, CFG_DATA_W'($urandom_range(0, 200)));
                end
                default: begin
                    write_reg(tcce_pkg::CFG_REGION_BASE,
                              CFG_DATA_W'($urandom_range(0, 16383)));
                    write_reg(tcce_pkg::CFG_REGION_SIZE, CFG_DATA_W'($urandom));
                end
            endcase
            if (phase == 2) begin
                // scroll down until the view wraps to within one row of zero,
                // then scroll up so the view wraps back under zero
                do
                    send_request(tcce_pkg::REQ_SCROLL_DOWN, BYTE_W'($urandom),
                                 BYTE_W'($urandom));
                while (view_q == 0 || view_q >= LINE_CELLS);
                repeat (2)
                    send_request(tcce_pkg::REQ_SCROLL_UP, BYTE_W'($urandom),
                                 BYTE_W'($urandom));
            end
            random_traffic(phase == 2 ? 100 : 285);
        end

        settle();
        repeat (8) @(posedge aclk);
        if (result_q.size() != 0)
            report_mismatch("missing words", result_q.size(), 0);

        $display("Sent %0d console requests and %0d register writes across 6 region settings;",
                 words_sent, cfg_writes);
        $display("compared %0d result words, %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/tcce_pkg.sv
rtl/tcce_update.sv
rtl/text_console_cursor_engine_core.sv
rtl/tcce_checker.sv
test/text_console_cursor_engine_core_tb.sv
